/* design/scfb_pkg.sv */
// Shared constants and command type for the checksum frame builder.
package scfb_pkg;

    localparam logic [7:0] FRAME_HEADER = 8'h88;
    localparam logic [7:0] MAX_PAYLOAD  = 8'd28;
    localparam int         LEFT_W       = 5;
    localparam int         QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic       start;
        logic       with_data;
        logic       close;
        logic [7:0] func;
        logic [7:0] len;
        logic [7:0] data;
    } cmd_t;

endpackage

/* design/sum_checksum_frame_builder.sv */
// Top level of the byte frame builder with an 8-bit sum checksum.
//
//  channel | direction | ports
//  --------+-----------+--------------------------------------------------------
//  s_      | in        | s_valid s_ready s_frame_function s_payload_length s_payload_byte
//  m_      | out       | m_valid m_ready m_out_byte m_frame_end
//
// One output byte per cycle unless m_ready stalls; a first transaction yields up to five
// bytes, a later one one or two, so the byte sequencer in the back end sets the rate.
// Input transactions are taken every cycle while the command queue has room.
// The first output byte reaches m_ after its command passes the queue and then the output register.
// Reset is synchronous and clears frame state, queue pointers and the output valid flag.
// Either side may stall independently; the queue absorbs QUEUE_DEPTH commands.
module sum_checksum_frame_builder #(
    parameter int QUEUE_DEPTH = scfb_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_frame_function,
    input  logic [7:0] s_payload_length,
    input  logic [7:0] s_payload_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_frame_end
);

    scfb_pkg::cmd_t push_cmd;
    scfb_pkg::cmd_t head_cmd;
    logic           push;
    logic           full;
    logic           pop;
    logic           head_valid;

    scfb_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_frame_function (s_frame_function),
        .s_payload_length (s_payload_length),
        .s_payload_byte   (s_payload_byte),
        .q_full           (full),
        .q_push           (push),
        .q_cmd            (push_cmd)
    );

    scfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    scfb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end)
    );

endmodule

/* design/scfb_front.sv */
// Front end: accepts input transactions, tracks frame position, issues commands.
module scfb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_frame_function,
    input  logic [7:0]          s_payload_length,
    input  logic [7:0]          s_payload_byte,
    input  logic                q_full,
    output logic                q_push,
    output scfb_pkg::cmd_t      q_cmd
);

    logic                        in_frame_reg, in_frame_next;
    logic [scfb_pkg::LEFT_W-1:0] left_reg, left_next;
    logic                        accept;
    logic                        too_long;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign too_long = s_payload_length > scfb_pkg::MAX_PAYLOAD;

    always_comb begin
        in_frame_next   = in_frame_reg;
        left_next       = left_reg;
        q_push          = 1'b0;
        q_cmd.func      = s_frame_function;
        q_cmd.len       = s_payload_length;
        q_cmd.data      = s_payload_byte;
        q_cmd.start     = !in_frame_reg;
        q_cmd.with_data = 1'b1;
        q_cmd.close     = 1'b0;
        if (accept) begin
            if (!in_frame_reg) begin
                // drop an oversize first transaction without output
                if (!too_long) begin
                    q_push          = 1'b1;
                    q_cmd.with_data = s_payload_length != 8'd0;
                    q_cmd.close     = s_payload_length <= 8'd1;
                    if (s_payload_length > 8'd1) begin
                        in_frame_next = 1'b1;
                        left_next     = s_payload_length[scfb_pkg::LEFT_W-1:0]
                                        - {{(scfb_pkg::LEFT_W-1){1'b0}}, 1'b1};
                    end
                end
            end else begin
                q_push      = 1'b1;
                q_cmd.close = left_reg <= {{(scfb_pkg::LEFT_W-1){1'b0}}, 1'b1};
                if (q_cmd.close) begin
                    in_frame_next = 1'b0;
                    left_next     = '0;
                end else begin
                    left_next = left_reg - {{(scfb_pkg::LEFT_W-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            left_reg     <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            left_reg     <= left_next;
        end
    end

    a_open_frame_has_left: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> left_reg != '0)
        else $error("open frame with no payload left");

endmodule

/* design/scfb_queue.sv */
// Short command queue between the front end and the byte sequencer.
module scfb_queue #(
    parameter int DEPTH = scfb_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  scfb_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output scfb_pkg::cmd_t head_cmd,
    output logic           head_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    scfb_pkg::cmd_t mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

/* design/scfb_back.sv */
// Back end: walks each command through its frame bytes and keeps the checksum.
module scfb_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  scfb_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_frame_end
);

    localparam logic [2:0] ST_HDR  = 3'd0;
    localparam logic [2:0] ST_FUNC = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_DATA = 3'd3;
    localparam logic [2:0] ST_CSUM = 3'd4;

    logic [2:0] step_reg, step_next;
    logic       started_reg, started_next;
    logic [7:0] sum_reg, sum_next;
    logic       m_valid_reg;
    logic [7:0] m_out_byte_reg;
    logic       m_frame_end_reg;
    logic [2:0] cur_step;
    logic       emit;
    logic       last;
    logic [7:0] byte_val;

    assign emit     = head_valid && (!m_valid_reg || m_ready);
    assign cur_step = started_reg ? step_reg : (head_cmd.start ? ST_HDR : ST_DATA);

    always_comb begin
        byte_val  = head_cmd.data;
        sum_next  = sum_reg;
        step_next = step_reg;
        last      = 1'b0;
        unique case (cur_step)
            ST_HDR: begin
                byte_val  = scfb_pkg::FRAME_HEADER;
                sum_next  = scfb_pkg::FRAME_HEADER;
                step_next = ST_FUNC;
            end
            ST_FUNC: begin
                byte_val  = head_cmd.func;
                sum_next  = sum_reg + head_cmd.func;
                step_next = ST_LEN;
            end
            ST_LEN: begin
                byte_val  = head_cmd.len;
                sum_next  = sum_reg + head_cmd.len;
                step_next = head_cmd.with_data ? ST_DATA : ST_CSUM;
            end
            ST_DATA: begin
                byte_val  = head_cmd.data;
                sum_next  = sum_reg + head_cmd.data;
                step_next = ST_CSUM;
                last      = !head_cmd.close;
            end
            ST_CSUM: begin
                byte_val  = sum_reg;
                last      = 1'b1;
            end
            default: begin
                byte_val  = sum_reg;
                last      = 1'b1;
            end
        endcase
    end

    assign pop          = emit && last;
    assign started_next = emit ? !last : started_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= ST_HDR;
            started_reg <= 1'b0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            started_reg <= started_next;
            if (emit) begin
                step_reg    <= step_next;
                sum_reg     <= sum_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold the payload while the transaction is stalled
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_out_byte_reg  <= byte_val;
            m_frame_end_reg <= cur_step == ST_CSUM;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_frame_end = m_frame_end_reg;

    a_started_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |-> head_valid)
        else $error("sequencer mid-command with empty queue");

    a_started_past_first: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |-> step_reg != ST_HDR)
        else $error("sequencer returned to header mid-command");

endmodule
